// File: sv/tone_vibrato_sweep_sound_control_macros.svh
// Assertion shorthands for the sound control checker.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef TONE_VIBRATO_SWEEP_SOUND_CONTROL_MACROS_SVH
`define TONE_VIBRATO_SWEEP_SOUND_CONTROL_MACROS_SVH

// Same-cycle implication
`define TVS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tvs_pkg.sv
`timescale 1ns / 1ps

package tvs_pkg;

    // Default number of ticks between 5/4 pitch step toggles on voice A
    localparam int TVS_STEP_INTERVAL = 4;
    // Entries in the command queue between front and back
    localparam int TVS_QUEUE_DEPTH = 2;

    // Item opcodes, also used as command kinds after decode
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Trigger codes on the result
    localparam logic [1:0] TRIG_NONE = 2'd0;
    localparam logic [1:0] TRIG_ONE  = 2'd1;
    localparam logic [1:0] TRIG_TWO  = 2'd2;

    // Frequency code that silences a voice
    localparam logic [3:0] CODE_OFF = 4'hf;

    typedef logic signed [17:0] sine_t;

    localparam sine_t SINE_NEG_ONE = -18'sd65536;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [18:0] rate_a;
        logic [6:0]  volume_a;
        logic [17:0] rate_b;
        logic [6:0]  volume_b;
        logic [12:0] noise_rate;
        logic [6:0]  noise_gain;
        logic [1:0]  effect_trigger;
        logic [1:0]  tune_trigger;
    } result_t;

    // Decoded command carried through the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  freq;
        logic [1:0]  hi;
        logic [6:0]  vol;
        logic [18:0] rate;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Voice A base rate: 308700 / (16 - code)
    function automatic logic [18:0] rate_a_tab(input logic [3:0] code);
        logic [18:0] r;
        case (code)
            4'd0:    r = 19'd19293;
            4'd1:    r = 19'd20580;
            4'd2:    r = 19'd22050;
            4'd3:    r = 19'd23746;
            4'd4:    r = 19'd25725;
            4'd5:    r = 19'd28063;
            4'd6:    r = 19'd30870;
            4'd7:    r = 19'd34300;
            4'd8:    r = 19'd38587;
            4'd9:    r = 19'd44100;
            4'd10:   r = 19'd51450;
            4'd11:   r = 19'd61740;
            4'd12:   r = 19'd77175;
            4'd13:   r = 19'd102900;
            4'd14:   r = 19'd154350;
            default: r = 19'd308700;
        endcase
        return r;
    endfunction

    // Voice B base rate: 176400 / (16 - code)
    function automatic logic [17:0] rate_b_tab(input logic [3:0] code);
        logic [17:0] r;
        case (code)
            4'd0:    r = 18'd11025;
            4'd1:    r = 18'd11760;
            4'd2:    r = 18'd12600;
            4'd3:    r = 18'd13569;
            4'd4:    r = 18'd14700;
            4'd5:    r = 18'd16036;
            4'd6:    r = 18'd17640;
            4'd7:    r = 18'd19600;
            4'd8:    r = 18'd22050;
            4'd9:    r = 18'd25200;
            4'd10:   r = 18'd29400;
            4'd11:   r = 18'd35280;
            4'd12:   r = 18'd44100;
            4'd13:   r = 18'd58800;
            4'd14:   r = 18'd88200;
            default: r = 18'd176400;
        endcase
        return r;
    endfunction

    // Volume field to percent: 100 * (3 - v) / 3
    function automatic logic [6:0] volume_pct(input logic [1:0] v);
        logic [6:0] p;
        case (v)
            2'd0:    p = 7'd100;
            2'd1:    p = 7'd66;
            2'd2:    p = 7'd33;
            default: p = 7'd0;
        endcase
        return p;
    endfunction

    // Noise rate for the noise bits: 1750 * (4 - hi)
    function automatic logic [12:0] noise_rate_tab(input logic [1:0] hi);
        logic [12:0] f;
        case (hi)
            2'd0:    f = 13'd7000;
            2'd1:    f = 13'd5250;
            2'd2:    f = 13'd3500;
            default: f = 13'd1750;
        endcase
        return f;
    endfunction

    // Noise starting level for the noise bits: 85 * hi
    function automatic logic [7:0] noise_start_level(input logic [1:0] hi);
        logic [7:0] l;
        case (hi)
            2'd0:    l = 8'd0;
            2'd1:    l = 8'd85;
            2'd2:    l = 8'd170;
            default: l = 8'd255;
        endcase
        return l;
    endfunction

    // Sine of 0.14 * idx in Q16, 45 steps
    function automatic sine_t vib_sine(input logic [5:0] idx);
        sine_t s;
        case (idx)
            6'd0:    s = 18'sd0;
            6'd1:    s = 18'sd9145;
            6'd2:    s = 18'sd18111;
            6'd3:    s = 18'sd26723;
            6'd4:    s = 18'sd34812;
            6'd5:    s = 18'sd42219;
            6'd6:    s = 18'sd48801;
            6'd7:    s = 18'sd54427;
            6'd8:    s = 18'sd58989;
            6'd9:    s = 18'sd62396;
            6'd10:   s = 18'sd64582;
            6'd11:   s = 18'sd65505;
            6'd12:   s = 18'sd65146;
            6'd13:   s = 18'sd63512;
            6'd14:   s = 18'sd60635;
            6'd15:   s = 18'sd56571;
            6'd16:   s = 18'sd51401;
            6'd17:   s = 18'sd45225;
            6'd18:   s = 18'sd38164;
            6'd19:   s = 18'sd30356;
            6'd20:   s = 18'sd21954;
            6'd21:   s = 18'sd13122;
            6'd22:   s = 18'sd4034;
            6'd23:   s = -18'sd5133;
            6'd24:   s = -18'sd14200;
            6'd25:   s = -18'sd22989;
            6'd26:   s = -18'sd31328;
            6'd27:   s = -18'sd39054;
            6'd28:   s = -18'sd46016;
            6'd29:   s = -18'sd52077;
            6'd30:   s = -18'sd57120;
            6'd31:   s = -18'sd61044;
            6'd32:   s = -18'sd63774;
            6'd33:   s = -18'sd65256;
            6'd34:   s = -18'sd65462;
            6'd35:   s = -18'sd64386;
            6'd36:   s = -18'sd62050;
            6'd37:   s = -18'sd58501;
            6'd38:   s = -18'sd53806;
            6'd39:   s = -18'sd48059;
            6'd40:   s = -18'sd41371;
            6'd41:   s = -18'sd33873;
            6'd42:   s = -18'sd25713;
            6'd43:   s = -18'sd17050;
            6'd44:   s = -18'sd8053;
            default: s = 18'sd0;
        endcase
        return s;
    endfunction

    // Cosine of 0.14 * idx in Q16, 23 steps
    function automatic sine_t sweep_cos(input logic [4:0] idx);
        sine_t s;
        case (idx)
            5'd0:    s = 18'sd65536;
            5'd1:    s = 18'sd64895;
            5'd2:    s = 18'sd62984;
            5'd3:    s = 18'sd59840;
            5'd4:    s = 18'sd55526;
            5'd5:    s = 18'sd50125;
            5'd6:    s = 18'sd43743;
            5'd7:    s = 18'sd36505;
            5'd8:    s = 18'sd28553;
            5'd9:    s = 18'sd20042;
            5'd10:   s = 18'sd11139;
            5'd11:   s = 18'sd2018;
            5'd12:   s = -18'sd7143;
            5'd13:   s = -18'sd16163;
            5'd14:   s = -18'sd24868;
            5'd15:   s = -18'sd33086;
            5'd16:   s = -18'sd40656;
            5'd17:   s = -18'sd47431;
            5'd18:   s = -18'sd53278;
            5'd19:   s = -18'sd58082;
            5'd20:   s = -18'sd61749;
            5'd21:   s = -18'sd64209;
            5'd22:   s = -18'sd65412;
            default: s = -18'sd65412;
        endcase
        return s;
    endfunction

endpackage

// File: sv/tvs_front.sv
`timescale 1ns / 1ps

module tvs_front
    import tvs_pkg::*;
(
    input  logic      item_valid,
    output logic      item_stall,
    input  item_t     item,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      cmd
);

    logic [3:0] freq;
    logic [1:0] vol_field;

    assign freq      = item.data[3:0];
    assign vol_field = item.data[5:4];

    // Hold the input while the queue has no room
    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    // Split the register byte and look up the direct rate and volume
    always_comb
    begin
        cmd.kind = item.opcode;
        cmd.freq = freq;
        cmd.hi   = item.data[7:6];
        cmd.vol  = (freq == CODE_OFF) ? 7'd0 : volume_pct(vol_field);
        case (item.opcode)
            OP_WRITE_A: cmd.rate = rate_a_tab(freq);
            OP_WRITE_B: cmd.rate = {1'b0, rate_b_tab(freq)};
            default:    cmd.rate = '0;
        endcase
    end

endmodule

// File: sv/tvs_queue.sv
`timescale 1ns / 1ps

module tvs_queue
    import tvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      wr_cmd,
    input  logic      pop,
    output cmd_t      rd_cmd,
    output q_status_t q_status
);

    localparam int DEPTH = TVS_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign rd_cmd         = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: sv/tvs_back.sv
`timescale 1ns / 1ps

module tvs_back
    import tvs_pkg::*;
#(
    parameter int STEP_INTERVAL = TVS_STEP_INTERVAL
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_data,
    input  cmd_t      cmd,
    input  q_status_t q_status,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    localparam int SCW = $clog2(STEP_INTERVAL + 1);

    localparam logic [5:0] VIB_STEPS     = 6'd45;
    localparam logic [5:0] SWEEP_TOP     = 6'd22;
    localparam logic [5:0] SWEEP_RESTART = 6'd23;
    localparam logic [5:0] SWEEP_LAST    = 6'd55;
    localparam logic [5:0] SWEEP_END     = 6'd56;

    // Multiplier values that leave a direct rate unchanged
    localparam logic [19:0] MA_UNITY = 20'd655360;
    localparam logic [20:0] MB_UNITY = 21'd1638400;

    // Reciprocals: /10 for voice A, /25 for voice B, *100/255 for noise
    localparam int          SA  = 26;
    localparam logic [45:0] KA  = 46'd6710887;
    localparam int          SB  = 28;
    localparam logic [46:0] KB  = 47'd10737419;
    localparam int          SN  = 23;
    localparam logic [29:0] KN  = 30'd3289700;

    typedef struct packed {
        logic        upd_rate_a;
        logic [18:0] xa;
        logic [19:0] ma;
        logic        upd_rate_b;
        logic [17:0] xb;
        logic [20:0] mb;
        logic        upd_vol_a;
        logic [6:0]  vol_a;
        logic        upd_vol_b;
        logic [6:0]  vol_b;
        logic        upd_noise_rate;
        logic [12:0] noise_rate;
        logic        upd_noise_vol;
        logic [7:0]  noise_lvl;
        logic [1:0]  eff;
        logic [1:0]  tune;
    } op_stage_t;

    typedef struct packed {
        logic        upd_rate_a;
        logic [38:0] prod_a;
        logic        upd_rate_b;
        logic [38:0] prod_b;
        logic        upd_vol_a;
        logic [6:0]  vol_a;
        logic        upd_vol_b;
        logic [6:0]  vol_b;
        logic        upd_noise_rate;
        logic [12:0] noise_rate;
        logic        upd_noise_vol;
        logic [7:0]  noise_lvl;
        logic [1:0]  eff;
        logic [1:0]  tune;
    } prod_stage_t;

    // Voice and effect state
    logic           noise_emulate_reg;
    logic [3:0]     code_a_reg, code_a_next;
    logic [3:0]     code_b_reg, code_b_next;
    logic           sweep_restart_reg, sweep_restart_next;
    logic           high_step_reg, high_step_next;
    logic [SCW-1:0] step_count_reg, step_count_next;
    logic [5:0]     vibrato_phase_reg, vibrato_phase_next;
    logic [5:0]     sweep_phase_reg, sweep_phase_next;
    logic [7:0]     noise_level_reg, noise_level_next;
    logic [12:0]    noise_hz_reg, noise_hz_next;
    logic [1:0]     last_noise_reg, last_noise_next;
    logic [1:0]     current_tune_reg, current_tune_next;

    // Pipeline
    logic           advance;
    logic           s2_valid_reg;
    op_stage_t      s2_reg, s2_next;
    logic           s3_valid_reg;
    prod_stage_t    s3_reg, s3_next;
    logic           result_valid_reg;
    result_t        result_reg, result_next;

    // Tick operands
    logic [18:0]        pa_base;
    logic [20:0]        pa_scaled;
    logic [18:0]        pa_step;
    logic [5:0]         vp;
    logic [5:0]         vp_inc;
    sine_t              s_vib;
    sine_t              s_swp;
    logic signed [20:0] ma_sum;
    logic signed [21:0] mb_sum;
    logic [SCW-1:0]     step_inc;
    logic [12:0]        nf;
    logic [7:0]         lvl;

    // Output stage arithmetic
    logic [45:0]        ra_full;
    logic [46:0]        rb_full;
    logic [29:0]        nv_full;

    assign advance      = !result_valid_reg || !result_stall;
    assign pop          = advance && !q_status.empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Tick operands from the present state
    assign pa_base   = rate_a_tab(code_a_reg);
    assign pa_scaled = 21'(pa_base) * 21'd5;
    assign pa_step   = high_step_reg ? pa_scaled[20:2] : pa_base;
    assign vp        = (vibrato_phase_reg < VIB_STEPS) ? vibrato_phase_reg : '0;
    assign vp_inc    = vp + 6'd1;
    assign s_vib     = vib_sine(vp);
    assign ma_sum    = 21'sd655360 + 21'(s_vib);
    assign step_inc  = step_count_reg + SCW'(1);
    assign mb_sum    = 22'sd1638400 + 22'(s_swp) * 22'sd6;

    // Sweep angle: falling half from pi/2, then the falling sine, then the floor
    always_comb
    begin
        if (sweep_phase_reg <= SWEEP_TOP)
        begin
            s_swp = sweep_cos(sweep_phase_reg[4:0]);
        end
        else if (sweep_phase_reg <= SWEEP_LAST)
        begin
            s_swp = vib_sine(sweep_phase_reg - SWEEP_TOP);
        end
        else
        begin
            s_swp = SINE_NEG_ONE;
        end
    end

    // Execute the head command: update state, build multiplier operands
    always_comb
    begin
        code_a_next        = code_a_reg;
        code_b_next        = code_b_reg;
        sweep_restart_next = sweep_restart_reg;
        high_step_next     = high_step_reg;
        step_count_next    = step_count_reg;
        vibrato_phase_next = vibrato_phase_reg;
        sweep_phase_next   = sweep_phase_reg;
        noise_level_next   = noise_level_reg;
        noise_hz_next      = noise_hz_reg;
        last_noise_next    = last_noise_reg;
        current_tune_next  = current_tune_reg;
        s2_next            = '0;
        nf                 = noise_rate_tab(cmd.hi);
        lvl                = noise_level_reg;

        if (pop)
        begin
            case (cmd.kind)
                OP_WRITE_A:
                begin
                    code_a_next = cmd.freq;
                    if (cmd.freq != CODE_OFF)
                    begin
                        s2_next.upd_rate_a = 1'b1;
                        s2_next.xa         = cmd.rate;
                        s2_next.ma         = MA_UNITY;
                    end
                    s2_next.upd_vol_a = 1'b1;
                    s2_next.vol_a     = cmd.vol;
                    if (noise_emulate_reg)
                    begin
                        if (noise_hz_reg != nf)
                        begin
                            noise_hz_next = nf;
                            lvl           = noise_start_level(cmd.hi);
                        end
                        s2_next.upd_noise_vol = 1'b1;
                        if (cmd.hi != 2'd0)
                        begin
                            s2_next.upd_noise_rate = 1'b1;
                            s2_next.noise_rate     = nf;
                            s2_next.noise_lvl      = lvl;
                            noise_level_next       = lvl;
                        end
                        else
                        begin
                            s2_next.noise_lvl = '0;
                            noise_level_next  = '0;
                        end
                    end
                    else
                    begin
                        // Fire a sample only when the selection changes
                        if ((cmd.hi == TRIG_ONE || cmd.hi == TRIG_TWO)
                            && last_noise_reg != cmd.hi)
                        begin
                            s2_next.eff = cmd.hi;
                        end
                        last_noise_next = cmd.hi;
                    end
                end
                OP_WRITE_B:
                begin
                    sweep_restart_next = (cmd.freq != code_b_reg);
                    code_b_next        = cmd.freq;
                    if (cmd.freq != CODE_OFF)
                    begin
                        s2_next.upd_rate_b = 1'b1;
                        s2_next.xb         = cmd.rate[17:0];
                        s2_next.mb         = MB_UNITY;
                    end
                    s2_next.upd_vol_b = 1'b1;
                    s2_next.vol_b     = cmd.vol;
                    if (cmd.hi == 2'd0)
                    begin
                        current_tune_next = 2'd0;
                    end
                    else if ((cmd.hi inside {[2'd2:2'd3]}) && current_tune_reg != cmd.hi)
                    begin
                        current_tune_next = cmd.hi;
                        s2_next.tune      = cmd.hi - 2'd1;
                    end
                end
                OP_TICK:
                begin
                    // Voice A: step and vibrato
                    s2_next.upd_rate_a = 1'b1;
                    s2_next.xa         = pa_step;
                    s2_next.ma         = ma_sum[19:0];
                    if (step_inc >= SCW'(STEP_INTERVAL))
                    begin
                        high_step_next  = !high_step_reg;
                        step_count_next = '0;
                    end
                    else
                    begin
                        step_count_next = step_inc;
                    end
                    vibrato_phase_next = (vp_inc < VIB_STEPS) ? vp_inc : '0;

                    // Voice B: sweep, restarted until the code repeats
                    s2_next.upd_rate_b = 1'b1;
                    s2_next.xb         = rate_b_tab(code_b_reg);
                    s2_next.mb         = mb_sum[20:0];
                    if (sweep_restart_reg)
                    begin
                        sweep_phase_next = SWEEP_RESTART;
                    end
                    else if (sweep_phase_reg < SWEEP_TOP)
                    begin
                        sweep_phase_next = sweep_phase_reg + 6'd1;
                    end
                    else if (sweep_phase_reg == SWEEP_TOP)
                    begin
                        sweep_phase_next = SWEEP_END;
                    end
                    else if (sweep_phase_reg < SWEEP_LAST)
                    begin
                        sweep_phase_next = sweep_phase_reg + 6'd1;
                    end
                    else
                    begin
                        sweep_phase_next = SWEEP_END;
                    end

                    // Noise decay, floored at zero
                    if (noise_level_reg != 8'd0 && noise_emulate_reg)
                    begin
                        s2_next.upd_noise_vol = 1'b1;
                        s2_next.noise_lvl     = noise_level_reg;
                        noise_level_next      = (noise_level_reg > 8'd3)
                                                ? noise_level_reg - 8'd3 : 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Multiply rates by their modulation factors
    always_comb
    begin
        s3_next.upd_rate_a     = s2_reg.upd_rate_a;
        s3_next.prod_a         = 39'(s2_reg.xa) * 39'(s2_reg.ma);
        s3_next.upd_rate_b     = s2_reg.upd_rate_b;
        s3_next.prod_b         = 39'(s2_reg.xb) * 39'(s2_reg.mb);
        s3_next.upd_vol_a      = s2_reg.upd_vol_a;
        s3_next.vol_a          = s2_reg.vol_a;
        s3_next.upd_vol_b      = s2_reg.upd_vol_b;
        s3_next.vol_b          = s2_reg.vol_b;
        s3_next.upd_noise_rate = s2_reg.upd_noise_rate;
        s3_next.noise_rate     = s2_reg.noise_rate;
        s3_next.upd_noise_vol  = s2_reg.upd_noise_vol;
        s3_next.noise_lvl      = s2_reg.noise_lvl;
        s3_next.eff            = s2_reg.eff;
        s3_next.tune           = s2_reg.tune;
    end

    // Scale products down and merge into the held outputs
    assign ra_full = 46'(s3_reg.prod_a[38:16]) * KA;
    assign rb_full = 47'(s3_reg.prod_b[38:16]) * KB;
    assign nv_full = 30'(s3_reg.noise_lvl) * KN;

    always_comb
    begin
        result_next = result_reg;
        if (s3_valid_reg)
        begin
            if (s3_reg.upd_rate_a)
            begin
                result_next.rate_a = ra_full[SA+18:SA];
            end
            if (s3_reg.upd_rate_b)
            begin
                result_next.rate_b = rb_full[SB+17:SB];
            end
            if (s3_reg.upd_vol_a)
            begin
                result_next.volume_a = s3_reg.vol_a;
            end
            if (s3_reg.upd_vol_b)
            begin
                result_next.volume_b = s3_reg.vol_b;
            end
            if (s3_reg.upd_noise_rate)
            begin
                result_next.noise_rate = s3_reg.noise_rate;
            end
            if (s3_reg.upd_noise_vol)
            begin
                result_next.noise_gain = nv_full[SN+6:SN];
            end
            result_next.effect_trigger = s3_reg.eff;
            result_next.tune_trigger   = s3_reg.tune;
        end
    end

    // Control state and held outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_emulate_reg <= 1'b1;
            code_a_reg        <= CODE_OFF;
            code_b_reg        <= CODE_OFF;
            sweep_restart_reg <= 1'b1;
            high_step_reg     <= 1'b0;
            step_count_reg    <= '0;
            vibrato_phase_reg <= '0;
            sweep_phase_reg   <= '0;
            noise_level_reg   <= '0;
            noise_hz_reg      <= 13'd1000;
            last_noise_reg    <= '0;
            current_tune_reg  <= '0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                noise_emulate_reg <= cfg_data;
            end
            code_a_reg        <= code_a_next;
            code_b_reg        <= code_b_next;
            sweep_restart_reg <= sweep_restart_next;
            high_step_reg     <= high_step_next;
            step_count_reg    <= step_count_next;
            vibrato_phase_reg <= vibrato_phase_next;
            sweep_phase_reg   <= sweep_phase_next;
            noise_level_reg   <= noise_level_next;
            noise_hz_reg      <= noise_hz_next;
            last_noise_reg    <= last_noise_next;
            current_tune_reg  <= current_tune_next;
            if (advance)
            begin
                s2_valid_reg     <= pop;
                s3_valid_reg     <= s2_valid_reg;
                result_valid_reg <= s3_valid_reg;
                result_reg       <= result_next;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

// File: sv/tone_vibrato_sweep_sound_control.sv
`timescale 1ns / 1ps

// Sound control for two tone voices and a noise voice. Each item is a control A write, a
// control B write, a frame tick or a no-op, and each item produces exactly one result
// carrying the held voice rates and volumes plus one-shot noise-sample and tune trigger
// codes. Items are taken one per clock while the queue has room; a decoded item waits in
// a two-entry queue, then passes through the voice state update, the rate multiplies and
// the reciprocal scaling into the output register. The input stalls only when the queue
// is full, which happens only after the output has been stalled.
// The noise_emulate register is written through the cfg port, which is always ready;
// write it only while no item is in flight.
module tone_vibrato_sweep_sound_control
    import tvs_pkg::*;
#(
    parameter int STEP_INTERVAL = TVS_STEP_INTERVAL
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      wr_cmd;
    cmd_t      rd_cmd;

    assign cfg_ready = 1'b1;

    // Decode incoming items
    tvs_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .cmd        (wr_cmd)
    );

    // Buffer decoded commands
    tvs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_cmd   (wr_cmd),
        .pop      (pop),
        .rd_cmd   (rd_cmd),
        .q_status (q_status)
    );

    // Execute commands and hold results
    tvs_back #(
        .STEP_INTERVAL (STEP_INTERVAL)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (rd_cmd),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: sv/tvs_checker.sv
`timescale 1ns / 1ps

`include "tone_vibrato_sweep_sound_control_macros.svh"

module tvs_checker
    import tvs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic out_held;
    logic vol_ok;
    logic trig_ok;

    // Flag a result transfer that the receiver holds back
    assign out_held = result_valid && result_stall;

    // Check volume ranges and trigger codes on the result payload
    assign vol_ok  = (result.volume_a <= 7'd100) && (result.volume_b <= 7'd100)
                     && (result.noise_gain <= 7'd100);
    assign trig_ok = (result.effect_trigger inside {TRIG_NONE, TRIG_ONE, TRIG_TWO})
                     && (result.tune_trigger inside {TRIG_NONE, TRIG_ONE, TRIG_TWO});

    // Hold a stalled result
    `TVS_ASSERT_NEXT(a_result_hold, out_held, result_valid && $stable(result), "result not held")

    // Keep every volume within percent range
    `TVS_ASSERT_IMPLY(a_volume_range, result_valid, vol_ok, "volume above 100 percent")

    // Emit only defined trigger codes
    `TVS_ASSERT_IMPLY(a_trigger_code, result_valid, trig_ok, "undefined trigger code")

    // Stall the input only after the output side held a transfer back
    `TVS_ASSERT_IMPLY(a_stall_cause, $rose(item_stall), $past(out_held), "stall without hold")

endmodule

bind tone_vibrato_sweep_sound_control tvs_checker u_tvs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: test/tone_vibrato_sweep_sound_control_test.sv
`timescale 1ns / 1ps

module tone_vibrato_sweep_sound_control_test;
    import tvs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int VIB_STEPS   = 45;
    localparam int SWEEP_END   = 56;

    // Tracks the voice settings and holds the results still owed by the block
    class voice_settings_board;
        bit          noise_mode;
        logic [3:0]  code_a;
        logic [3:0]  code_b;
        bit          sweep_restart;
        bit          high_step;
        int          step_count;
        int          vibrato_phase;
        int          sweep_phase;
        int          noise_level;
        int          noise_hz;
        logic [1:0]  last_noise;
        logic [1:0]  current_tune;
        result_t     held;
        result_t     expected_settings[$];
        int          failures;
        int          vib_q16[45];
        int          cos_q16[23];

        function new();
            noise_mode    = 1'b1;
            code_a        = CODE_OFF;
            code_b        = CODE_OFF;
            sweep_restart = 1'b1;
            high_step     = 1'b0;
            step_count    = 0;
            vibrato_phase = 0;
            sweep_phase   = 0;
            noise_level   = 0;
            noise_hz      = 1000;
            last_noise    = 2'd0;
            current_tune  = 2'd0;
            held          = '0;
            failures      = 0;
            vib_q16 = '{0, 9145, 18111, 26723, 34812, 42219, 48801, 54427, 58989, 62396,
                        64582, 65505, 65146, 63512, 60635, 56571, 51401, 45225, 38164,
                        30356, 21954, 13122, 4034, -5133, -14200, -22989, -31328, -39054,
                        -46016, -52077, -57120, -61044, -63774, -65256, -65462, -64386,
                        -62050, -58501, -53806, -48059, -41371, -33873, -25713, -17050,
                        -8053};
            cos_q16 = '{65536, 64895, 62984, 59840, 55526, 50125, 43743, 36505, 28553,
                        20042, 11139, 2018, -7143, -16163, -24868, -33086, -40656, -47431,
                        -53278, -58082, -61749, -64209, -65412};
        endfunction

        function int pending();
            return expected_settings.size();
        endfunction

        // Sweep angle: cosine half first, then the falling sine, then the bottom
        function longint sweep_q16(int p);
            if (p <= 22)
                return cos_q16[p];
            if (p <= 55)
                return vib_q16[p - 22];
            return -65536;
        endfunction

        function int sweep_advance(int p);
            if (sweep_restart)
                return 23;
            if (p < 22)
                return p + 1;
            if (p == 22)
                return SWEEP_END;
            if (p < 55)
                return p + 1;
            return SWEEP_END;
        endfunction

        function logic [6:0] percent(logic [1:0] v);
            return 7'(100 * (3 - int'(v)) / 3);
        endfunction

        // Apply one accepted transfer and queue the result it produces
        function void take_command(item_t it);
            logic [3:0] freq;
            logic [1:0] vol;
            logic [1:0] hi;
            int         nf;
            int         vp;
            longint     pa;
            longint     pb;
            result_t    want;

            freq = it.data[3:0];
            vol  = it.data[5:4];
            hi   = it.data[7:6];
            held.effect_trigger = TRIG_NONE;
            held.tune_trigger   = TRIG_NONE;

            case (it.opcode)
                OP_WRITE_A:
                begin
                    code_a = freq;
                    if (freq != CODE_OFF)
                    begin
                        held.rate_a   = 19'(308700 / (16 - int'(freq)));
                        held.volume_a = percent(vol);
                    end
                    else
                        held.volume_a = '0;
                    if (noise_mode)
                    begin
                        nf = 1750 * (4 - int'(hi));
                        if (noise_hz != nf)
                        begin
                            noise_hz    = nf;
                            noise_level = 85 * int'(hi);
                        end
                        if (hi != 2'd0)
                        begin
                            held.noise_rate = 13'(noise_hz);
                            held.noise_gain = 7'(noise_level * 100 / 255);
                        end
                        else
                        begin
                            held.noise_gain = '0;
                            noise_level     = 0;
                        end
                    end
                    else
                    begin
                        if ((hi == 2'd1 || hi == 2'd2) && last_noise != hi)
                            held.effect_trigger = hi;
                        last_noise = hi;
                    end
                end
                OP_WRITE_B:
                begin
                    sweep_restart = (freq != code_b);
                    code_b        = freq;
                    if (freq != CODE_OFF)
                    begin
                        held.rate_b   = 18'(176400 / (16 - int'(freq)));
                        held.volume_b = percent(vol);
                    end
                    else
                        held.volume_b = '0;
                    if (hi == 2'd0)
                        current_tune = 2'd0;
                    else if (hi >= 2'd2 && current_tune != hi)
                    begin
                        current_tune      = hi;
                        held.tune_trigger = hi - 2'd1;
                    end
                end
                OP_TICK:
                begin
                    pa = 308700 / (16 - longint'(code_a));
                    pb = 176400 / (16 - longint'(code_b));
                    vp = (vibrato_phase < VIB_STEPS) ? vibrato_phase : 0;

                    // Voice A: pitch step, then vibrato
                    if (high_step)
                        pa = pa * 5 / 4;
                    pa = pa * (655360 + longint'(vib_q16[vp])) / 655360;
                    step_count++;
                    if (step_count >= TVS_STEP_INTERVAL)
                    begin
                        high_step  = !high_step;
                        step_count = 0;
                    end
                    vibrato_phase = (vp + 1 < VIB_STEPS) ? vp + 1 : 0;

                    // Voice B: sweep
                    pb = pb * (1638400 + 6 * sweep_q16(sweep_phase)) / 1638400;
                    sweep_phase = sweep_advance(sweep_phase);

                    held.rate_a = 19'(pa);
                    held.rate_b = 18'(pb);

                    // Decay the synthesized noise, stopping at zero
                    if (noise_level != 0 && noise_mode)
                    begin
                        held.noise_gain = 7'(noise_level * 100 / 255);
                        noise_level = (noise_level > 3) ? noise_level - 3 : 0;
                    end
                end
                default:
                begin
                end
            endcase

            want = held;
            expected_settings.push_back(want);
        endfunction

        function bit field_differs(string name, int want, int got);
            if (want == got)
                return 1'b0;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b1;
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_voice_result(result_t got);
            result_t want;
            bit      bad;

            if (expected_settings.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, got);
                failures++;
                return;
            end
            want = expected_settings.pop_front();
            bad  = 1'b0;
            bad |= field_differs("rate_a", want.rate_a, got.rate_a);
            bad |= field_differs("volume_a", want.volume_a, got.volume_a);
            bad |= field_differs("rate_b", want.rate_b, got.rate_b);
            bad |= field_differs("volume_b", want.volume_b, got.volume_b);
            bad |= field_differs("noise_rate", want.noise_rate, got.noise_rate);
            bad |= field_differs("noise_gain", want.noise_gain, got.noise_gain);
            bad |= field_differs("effect_trigger", want.effect_trigger, got.effect_trigger);
            bad |= field_differs("tune_trigger", want.tune_trigger, got.tune_trigger);
            if (bad)
                failures++;
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item_in;
    logic    result_valid;
    logic    result_stall;
    result_t result_out;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_data;

    voice_settings_board board;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;
    int      cycle_count;
    int      items_sent;
    logic [3:0] last_b_code;

    tone_vibrato_sweep_sound_control dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tone_vibrato_sweep_sound_control test failed");
            $finish;
        end
    end

    // Drive the result stall: a requested hold-off first, else random
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_voice_result(result_out);
    end

    // Offer one item, idling first at random, and hold it until taken
    task automatic send(logic [1:0] op, logic [7:0] d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid     <= 1'b1;
        item_in.opcode <= op;
        item_in.data   <= d;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.take_command(item_in);
        if (op == OP_WRITE_B)
            last_b_code = d[3:0];
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_noise_mode(logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.noise_mode = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random frames: mostly bursts of ticks, with voice writes in between
    task automatic run_random(int count, bit pause_midway);
        int stop_at;
        int burst;
        int pick;
        bit paused;

        stop_at = items_sent + count;
        paused  = 1'b0;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(9);
            if (pick <= 5)
            begin
                burst = ($urandom_range(5) == 0) ? $urandom_range(70, 40) : $urandom_range(8, 1);
                repeat (burst) send(OP_TICK, 8'($urandom));
            end
            else if (pick == 6)
                send(OP_WRITE_A, 8'($urandom));
            else if (pick <= 8)
            begin
                // Mostly keep voice B on its code so the sweep can run
                if ($urandom_range(3) != 0)
                    send(OP_WRITE_B, {2'($urandom), 2'($urandom), last_b_code});
                else
                    send(OP_WRITE_B, 8'($urandom));
            end
            else if ($urandom_range(1) == 0)
                send(OP_NONE, 8'($urandom));
            else
                send(OP_WRITE_A, 8'($urandom));

            // Hold the sender until the block has answered everything
            if (pause_midway && !paused && items_sent >= stop_at - count / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_in        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        cycle_count    = 0;
        items_sent     = 0;
        last_b_code    = CODE_OFF;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: synthesized noise, tone extremes, tune triggers
        write_noise_mode(1'b1);
        send(OP_TICK, 8'h00);
        send(OP_WRITE_B, 8'h0F);
        send(OP_TICK, 8'hFF);
        send(OP_WRITE_A, 8'h00);
        send(OP_WRITE_A, 8'h7E);
        send(OP_TICK, 8'h00);
        send(OP_TICK, 8'h00);
        send(OP_WRITE_A, 8'hB5);
        send(OP_WRITE_A, 8'hFF);
        send(OP_TICK, 8'h00);
        send(OP_WRITE_A, 8'hFF);
        send(OP_WRITE_B, 8'h00);
        send(OP_WRITE_B, 8'h40);
        send(OP_WRITE_B, 8'h80);
        send(OP_WRITE_B, 8'h80);
        send(OP_WRITE_B, 8'hDE);
        send(OP_TICK, 8'h00);
        send(OP_NONE, 8'hAA);
        send(OP_TICK, 8'h55);
        wait_drained();

        // Directed: recorded noise samples
        write_noise_mode(1'b0);
        send(OP_WRITE_A, 8'h40);
        send(OP_WRITE_A, 8'h40);
        send(OP_WRITE_A, 8'h8F);
        send(OP_WRITE_A, 8'hC0);
        send(OP_WRITE_A, 8'h43);
        send(OP_TICK, 8'h00);
        wait_drained();

        // No idling, with a long receiver hold-off to back the block up
        write_noise_mode(1'b1);
        hold_cycles = 60;
        run_random(160, 1'b0);
        wait_drained();

        // Sender mostly idle
        write_noise_mode(1'b0);
        send_idle_pct = 81;
        run_random(160, 1'b0);
        wait_drained();

        // Receiver mostly stalled
        write_noise_mode(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random(160, 1'b0);
        wait_drained();

        // Light idling on both sides, with a full drain midway
        write_noise_mode(1'b0);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(170, 1'b1);
        wait_drained();

        if (board.failures == 0)
            $display("tone_vibrato_sweep_sound_control test passed");
        else
            $display("tone_vibrato_sweep_sound_control test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/tvs_pkg.sv
sv/tvs_front.sv
sv/tvs_queue.sv
sv/tvs_back.sv
sv/tone_vibrato_sweep_sound_control.sv
sv/tvs_checker.sv
test/tone_vibrato_sweep_sound_control_test.sv
